// ===== hw/rtl/wheel_drive_mixer_defines.svh =====
// Assertion helpers for the wheel drive mixer.
// All checks are clocked on i_clk and switched off while i_rst_n is low.
`ifndef WHEEL_DRIVE_MIXER_DEFINES_SVH
`define WHEEL_DRIVE_MIXER_DEFINES_SVH

`ifndef SYNTH
`define WDM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wheel_drive_mixer: check failed");
`define WDM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wheel_drive_mixer: check failed");
`else
`define WDM_ASSERT_IMPL(lbl, ante, cons)
`define WDM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/wdm_pkg.sv =====
package wdm_pkg;

    localparam int IN_W    = 16;
    localparam int WHEEL_W = 18;  // x - y + w needs two guard bits
    localparam int MAG_W   = 17;
    localparam int REM_W   = MAG_W + 1;
    localparam int QUO_W   = 15;  // normalised magnitude is at most 16384
    localparam int OUT_W   = 16;
    localparam int PROD_W  = 32;
    localparam int NUM_WHEELS = 4;

    localparam int STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

    localparam int WDM_QUEUE_DEPTH = 4;

    localparam logic [MAG_W-1:0]         Q14_ONE    = MAG_W'(16384);
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(16383);
    localparam logic signed [PROD_W-1:0] SAT_HI     = PROD_W'(32767);
    localparam logic signed [PROD_W-1:0] SAT_LO     = -PROD_W'(32768);

    localparam logic [1:0] MODE_MECANUM    = 2'd0;
    localparam logic [1:0] MODE_FOUR_PAR   = 2'd1;
    localparam logic [1:0] MODE_TWO_PAR    = 2'd2;
    localparam logic [1:0] MODE_SINGLE     = 2'd3;

    localparam logic CFG_DRIVE_MODE  = 1'b0;
    localparam logic CFG_OUTPUT_GAIN = 1'b1;

    localparam logic [1:0]             DRIVE_MODE_RESET  = MODE_MECANUM;
    localparam logic signed [IN_W-1:0] OUTPUT_GAIN_RESET = 16'sd256;

    // One mixed motion vector, held as magnitude and sign per wheel.
    typedef struct packed {
        logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
        logic [NUM_WHEELS-1:0]            neg;
    } t_q_entry;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             qbit;
    } t_div_res;

    // One restoring division step; the remainder comes back already doubled.
    function automatic t_div_res div_step(input logic [REM_W-1:0] rem,
                                          input logic [MAG_W-1:0] dv);
        logic [REM_W-1:0] t;
        t_div_res         res;
        t        = rem;
        res.qbit = 1'b0;
        if (rem >= {1'b0, dv}) begin
            t        = rem - {1'b0, dv};
            res.qbit = 1'b1;
        end
        res.rem = {t[REM_W-2:0], 1'b0};
        return res;
    endfunction

endpackage

// ===== hw/rtl/wdm_front.sv =====
module wdm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_valid,
    output logic                        o_s_ready,
    input  logic signed [15:0]          i_vel_x,
    input  logic signed [15:0]          i_vel_y,
    input  logic signed [15:0]          i_yaw_rate,
    input  logic [1:0]                  i_drive_mode,
    output logic                        o_q_push,
    output wdm_pkg::t_q_entry           o_q_entry,
    input  logic                        i_q_full
);
    import wdm_pkg::*;

    logic     r_valid;
    t_q_entry r_entry;
    t_q_entry n_entry;

    logic signed [WHEEL_W-1:0] x, y, w;
    logic signed [WHEEL_W-1:0] wh [NUM_WHEELS];

    assign x = WHEEL_W'(i_vel_x);
    assign y = WHEEL_W'(i_vel_y);
    assign w = WHEEL_W'(i_yaw_rate);

    always_comb begin
        for (int l = 0; l < NUM_WHEELS; l++) begin
            wh[l] = '0;
        end
        unique case (i_drive_mode)
            MODE_MECANUM: begin
                wh[0] = x - y + w;
                wh[1] = x + y + w;
                wh[2] = -x + y + w;
                wh[3] = -x - y + w;
            end
            MODE_FOUR_PAR: begin
                wh[0] = -x;
                wh[1] = x;
                wh[2] = x;
                wh[3] = -x;
            end
            MODE_TWO_PAR: begin
                wh[0] = -x;
                wh[1] = x;
            end
            MODE_SINGLE: begin
                wh[0] = x;
            end
        endcase
        // Unused wheels stay zero, so they never win the maximum and
        // come out of the gain stage as zero.
        for (int l = 0; l < NUM_WHEELS; l++) begin
            n_entry.neg[l] = wh[l][WHEEL_W-1];
            n_entry.mag[l] = wh[l][WHEEL_W-1] ? MAG_W'(-wh[l]) : MAG_W'(wh[l]);
        end
    end

    assign o_s_ready = !r_valid || !i_q_full;
    assign o_q_push  = r_valid && !i_q_full;
    assign o_q_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_s_valid && o_s_ready) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_valid && o_s_ready) begin
            r_entry <= n_entry;
        end
    end

endmodule

// ===== hw/rtl/wdm_queue.sv =====
module wdm_queue #(
    parameter int DEPTH = wdm_pkg::WDM_QUEUE_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wdm_pkg::t_q_entry i_entry,
    output logic              o_full,
    output logic              o_valid,
    output wdm_pkg::t_q_entry o_entry,
    input  logic              i_pop,
    output logic [CNT_W-1:0]  o_count
);
    import wdm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_q_entry         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== hw/rtl/wdm_back.sv =====
module wdm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  wdm_pkg::t_q_entry    i_q_entry,
    output logic                 o_q_pop,
    input  logic signed [15:0]   i_gain,
    output logic                 o_m_valid,
    input  logic                 i_m_ready,
    output logic [63:0]          o_m_data
);
    import wdm_pkg::*;

    logic en;

    // Entry stage
    logic     r_a_valid;
    t_q_entry r_a_entry;

    // Division pipeline; index 0 is the seeded stage.
    logic [DIV_STAGES:0]   r_dv;
    logic [REM_W-1:0]      r_rem [DIV_STAGES+1][NUM_WHEELS];
    logic [QUO_W-1:0]      r_quo [DIV_STAGES+1][NUM_WHEELS];
    logic [NUM_WHEELS-1:0] r_neg [DIV_STAGES+1];
    logic [MAG_W-1:0]      r_div [DIV_STAGES+1];
    logic [REM_W-1:0]      n_rem [DIV_STAGES][NUM_WHEELS];
    logic [QUO_W-1:0]      n_quo [DIV_STAGES][NUM_WHEELS];

    // Gain and output stages
    logic                     r_m_valid;
    logic signed [PROD_W-1:0] r_prod [NUM_WHEELS];
    logic signed [PROD_W-1:0] n_prod [NUM_WHEELS];
    logic                     r_o_valid;
    logic signed [OUT_W-1:0]  r_out  [NUM_WHEELS];
    logic signed [OUT_W-1:0]  n_out  [NUM_WHEELS];

    logic [MAG_W-1:0] max01, max23, max_all, n_div0;

    assign en      = !r_o_valid || i_m_ready;
    assign o_q_pop = i_q_valid && en;

    // Without normalisation the divisor is 1.0, so the quotient is the
    // magnitude itself and one path serves both cases.
    always_comb begin
        max01   = (r_a_entry.mag[0] > r_a_entry.mag[1]) ? r_a_entry.mag[0] : r_a_entry.mag[1];
        max23   = (r_a_entry.mag[2] > r_a_entry.mag[3]) ? r_a_entry.mag[2] : r_a_entry.mag[3];
        max_all = (max01 > max23) ? max01 : max23;
        n_div0  = (max_all > Q14_ONE) ? max_all : Q14_ONE;
    end

    always_comb begin
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        t_div_res         st;
        for (int s = 0; s < DIV_STAGES; s++) begin
            for (int l = 0; l < NUM_WHEELS; l++) begin
                rem = r_rem[s][l];
                quo = r_quo[s][l];
                for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                    st  = div_step(rem, r_div[s]);
                    rem = st.rem;
                    quo = {quo[QUO_W-2:0], st.qbit};
                end
                n_rem[s][l] = rem;
                n_quo[s][l] = quo;
            end
        end
    end

    always_comb begin
        logic signed [OUT_W-1:0]  val;
        logic signed [PROD_W-1:0] adj;
        logic signed [PROD_W-1:0] sh;
        for (int l = 0; l < NUM_WHEELS; l++) begin
            val = r_neg[DIV_STAGES][l] ? -$signed({1'b0, r_quo[DIV_STAGES][l]})
                                       :  $signed({1'b0, r_quo[DIV_STAGES][l]});
            n_prod[l] = val * i_gain;
        end
        for (int l = 0; l < NUM_WHEELS; l++) begin
            // Division by 16384 truncates toward zero.
            adj = r_prod[l] + (r_prod[l][PROD_W-1] ? ROUND_BIAS : '0);
            sh  = adj >>> 14;
            if (sh > SAT_HI) begin
                n_out[l] = SAT_HI[OUT_W-1:0];
            end else if (sh < SAT_LO) begin
                n_out[l] = SAT_LO[OUT_W-1:0];
            end else begin
                n_out[l] = sh[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_dv      <= '0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_q_valid;
            r_dv      <= {r_dv[DIV_STAGES-1:0], r_a_valid};
            r_m_valid <= r_dv[DIV_STAGES];
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_entry <= i_q_entry;
            r_div[0]  <= n_div0;
            r_neg[0]  <= r_a_entry.neg;
            for (int l = 0; l < NUM_WHEELS; l++) begin
                r_rem[0][l] <= {1'b0, r_a_entry.mag[l]};
                r_quo[0][l] <= '0;
            end
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_div[s+1] <= r_div[s];
                r_neg[s+1] <= r_neg[s];
                for (int l = 0; l < NUM_WHEELS; l++) begin
                    r_rem[s+1][l] <= n_rem[s][l];
                    r_quo[s+1][l] <= n_quo[s][l];
                end
            end
            for (int l = 0; l < NUM_WHEELS; l++) begin
                r_prod[l] <= n_prod[l];
                r_out[l]  <= n_out[l];
            end
        end
    end

    assign o_m_valid = r_o_valid;
    assign o_m_data  = {r_out[3], r_out[2], r_out[1], r_out[0]};

endmodule

// ===== hw/rtl/wheel_drive_mixer.sv =====
// Wheel drive mixer: one motion vector in, four wheel commands out.
// One beat per cycle unless the output stalls; nothing is carried between vectors.
// Each vector passes the mixing register, the queue, the entry register,
// the 15-step divider over five stages, and the gain and output registers.
// Reset (synchronous, active low) empties the pipeline and queue and loads
// drive_mode = mecanum and output_gain = 256.
`include "wheel_drive_mixer_defines.svh"

module wheel_drive_mixer #(
    parameter int QUEUE_DEPTH = wdm_pkg::WDM_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // vel_x, vel_y, yaw_rate
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // wheel_a, wheel_b, wheel_c, wheel_d
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);
    import wdm_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [1:0]              r_drive_mode;
    logic signed [IN_W-1:0]  r_gain;

    logic             q_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    t_q_entry         q_in;
    t_q_entry         q_out;
    logic [CNT_W-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_mode <= DRIVE_MODE_RESET;
            r_gain       <= OUTPUT_GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DRIVE_MODE:  r_drive_mode <= i_cfg_data[1:0];
                CFG_OUTPUT_GAIN: r_gain       <= $signed(i_cfg_data);
            endcase
        end
    end

    wdm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (i_s_axis_tvalid),
        .o_s_ready    (o_s_axis_tready),
        .i_vel_x      ($signed(i_s_axis_tdata[15:0])),
        .i_vel_y      ($signed(i_s_axis_tdata[31:16])),
        .i_yaw_rate   ($signed(i_s_axis_tdata[47:32])),
        .i_drive_mode (r_drive_mode),
        .o_q_push     (q_push),
        .o_q_entry    (q_in),
        .i_q_full     (q_full)
    );

    wdm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_out),
        .i_pop   (q_pop),
        .o_count (q_count)
    );

    wdm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_out),
        .o_q_pop   (q_pop),
        .i_gain    (r_gain),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (o_m_axis_tdata)
    );

    // A stalled result beat freezes the back end, so nothing leaves the queue.
    `WDM_ASSERT_IMPL(a_no_pop_when_stalled, o_m_axis_tvalid && !i_m_axis_tready, !q_pop)
    `WDM_ASSERT_IMPL(a_count_bounded, 1'b1, q_count <= CNT_W'(QUEUE_DEPTH))
    `WDM_ASSERT_NEXT(a_count_up, q_push && !q_pop, q_count == CNT_W'($past(q_count) + 1'b1))

endmodule
